>>> rtl/rcsort_pkg.sv
// Shared types and constants for the record insertion sorter.
// Holds operation and status codes, and the command and status structs
// that join the controller and the datapath. No dependencies.
package rcsort_pkg;

	localparam int MAX_RECORDS_DEF  = 256;
	localparam int RECORD_BYTES_DEF = 8;

	localparam int OP_W  = 2;
	localparam int REC_W = 64;
	localparam int ST_W  = 2;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_READ   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		RES_OK,
		RES_FULL,
		RES_EMPTY,
		RES_READ
	} res_t;

	typedef enum logic [1:0] {
		RA_CNT_M1,
		RA_IDX_M2,
		RA_PTR
	} raddr_sel_t;

	typedef struct packed {
		logic       capture;
		logic       rd_en;
		raddr_sel_t rd_sel;
		logic       wr_shift;
		logic       wr_place;
		logic       count_clear;
		logic       ptr_clear;
		logic       ptr_inc;
		logic       out_load;
		res_t       res;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic count_zero;
		logic ptr_ok;
		logic key_gt;
		logic idx_one;
	} stat_t;

endpackage

>>> rtl/rcsort_if.sv
// Valid/ready channel interfaces for the record insertion sorter.
// Depends on rcsort_pkg for the payload widths.
interface rcsort_in_if
	import rcsort_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [REC_W-1:0] record_in;

	modport source(output valid, output operation, output record_in, input ready);
	modport sink(input valid, input operation, input record_in, output ready);
endinterface

interface rcsort_out_if
	import rcsort_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic [REC_W-1:0] record_out;
	logic             last_record;
	logic [ST_W-1:0]  status;

	modport source(output valid, output record_out, output last_record, output status,
		input ready);
	modport sink(input valid, input record_out, input last_record, input status,
		output ready);
endinterface

>>> rtl/record_insertion_sorter.sv
// Channel   | Dir | Payload
// req       | in  | operation, record_in
// rsp       | out | record_out, last_record, status
// Top level of the record insertion sorter; depends on rcsort_pkg,
// rcsort_if, rcsort_ctrl and rcsort_dp.
// An insert moves every stored record with a greater key up by one place;
// the shift moves one record per cycle through the single read and single
// write port of the record memory. One item is worked at a time; the next
// is taken while a result waits in the output register and holds in its
// finish state until that result is taken.
// Reset needs no clearing pass.
module record_insertion_sorter
	import rcsort_pkg::*;
#(
	parameter int MAX_RECORDS  = MAX_RECORDS_DEF,
	parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rcsort_in_if.sink   req,
	rcsort_out_if.source rsp
);

	cmd_t  cmd;
	stat_t stat;

	rcsort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.operation (req.operation),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rcsort_dp #(
		.MAX_RECORDS  (MAX_RECORDS),
		.RECORD_BYTES (RECORD_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.record_in   (req.record_in),
		.record_out  (rsp.record_out),
		.last_record (rsp.last_record),
		.status      (rsp.status)
	);

endmodule

>>> rtl/rcsort_dp.sv
// Datapath of the record insertion sorter: record memory, count, read
// pointer, shift index and the result register. Driven by rcsort_ctrl.
// Depends on rcsort_pkg.
module rcsort_dp
	import rcsort_pkg::*;
#(
	parameter int MAX_RECORDS  = MAX_RECORDS_DEF,
	parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output stat_t            stat,
	input  logic [REC_W-1:0] record_in,
	output logic [REC_W-1:0] record_out,
	output logic             last_record,
	output logic [ST_W-1:0]  status
);

	localparam int RW = 8 * RECORD_BYTES;
	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = $clog2(MAX_RECORDS + 1);

	logic [RW-1:0] mem [MAX_RECORDS];
	logic [RW-1:0] rdata_q;
	logic [RW-1:0] rec_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic [AW-1:0] raddr;
	logic [RW-1:0] wdata;
	logic          last_hit;

	always_comb begin
		case (cmd.rd_sel)
			RA_CNT_M1: raddr = AW'(count_q - CW'(1));
			RA_IDX_M2: raddr = idx_q - AW'(2);
			RA_PTR:    raddr = ptr_q[AW-1:0];
			default:   raddr = '0;
		endcase
	end

	assign wdata    = cmd.wr_shift ? rdata_q : rec_q;
	assign last_hit = (ptr_q + CW'(1)) == count_q;

	assign stat.full       = count_q == CW'(MAX_RECORDS);
	assign stat.count_zero = count_q == '0;
	assign stat.ptr_ok     = ptr_q < count_q;
	assign stat.key_gt     = $signed(rdata_q[7:0]) > $signed(rec_q[7:0]);
	assign stat.idx_one    = idx_q == AW'(1);

	always_ff @(posedge clk) begin
		if (cmd.wr_shift || cmd.wr_place) begin
			mem[idx_q] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
		if (cmd.capture) begin
			rec_q <= record_in[RW-1:0];
		end
		if (cmd.capture) begin
			idx_q <= count_q[AW-1:0];
		end else if (cmd.wr_shift) begin
			idx_q <= idx_q - AW'(1);
		end
		if (cmd.out_load) begin
			case (cmd.res)
				RES_READ: begin
					record_out  <= REC_W'(rdata_q);
					last_record <= last_hit;
					status      <= ST_OK;
				end
				RES_FULL: begin
					record_out  <= '0;
					last_record <= 1'b0;
					status      <= ST_FULL;
				end
				RES_EMPTY: begin
					record_out  <= '0;
					last_record <= 1'b0;
					status      <= ST_EMPTY;
				end
				default: begin
					record_out  <= '0;
					last_record <= 1'b0;
					status      <= ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.count_clear) begin
				count_q <= '0;
			end else if (cmd.wr_place) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.ptr_clear) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_RECORDS))
		else $error("record count exceeds table depth");
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= count_q)
		else $error("read pointer beyond record count");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_shift && cmd.wr_place))
		else $error("shift and place in the same cycle");
	a_place_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_place |-> !stat.full)
		else $error("record placed into a full table");
`endif

endmodule

>>> rtl/rcsort_ctrl.sv
// Controller of the record insertion sorter: sequences insert scans,
// reads, clears and the hand-off to the result register.
// Depends on rcsort_pkg; drives rcsort_dp through cmd_t.
module rcsort_ctrl
	import rcsort_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  logic [OP_W-1:0] operation,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  stat_t           stat,
	output cmd_t            cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PLACE,
		S_RDWAIT,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	res_t   res_q;
	res_t   res_d;
	logic   out_valid_q;

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.res = res_q;
		state_d = state_q;
		res_d   = res_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_FINISH;
					res_d       = RES_OK;
					case (operation)
						OP_INSERT: begin
							cmd.ptr_clear = 1'b1;
							if (stat.full) begin
								res_d = RES_FULL;
							end else if (stat.count_zero) begin
								state_d = S_PLACE;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RA_CNT_M1;
								state_d    = S_SCAN;
							end
						end
						OP_READ: begin
							if (stat.ptr_ok) begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RA_PTR;
								res_d      = RES_READ;
								state_d    = S_RDWAIT;
							end else begin
								res_d = RES_EMPTY;
							end
						end
						OP_CLEAR: begin
							cmd.count_clear = 1'b1;
							cmd.ptr_clear   = 1'b1;
						end
						default: begin
							res_d = RES_OK;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (stat.key_gt) begin
					cmd.wr_shift = 1'b1;
					if (stat.idx_one) begin
						state_d = S_PLACE;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RA_IDX_M2;
					end
				end else begin
					cmd.wr_place = 1'b1;
					state_d      = S_FINISH;
				end
			end
			S_PLACE: begin
				cmd.wr_place = 1'b1;
				state_d      = S_FINISH;
			end
			S_RDWAIT: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					cmd.ptr_inc  = res_q == RES_READ;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_q       <= RES_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> bench/record_insertion_sorter_tb.sv
// Self-checking testbench for record_insertion_sorter: predicts every reply from a
// mirror of the sorted record table and checks it field by field.
// Depends on rcsort_pkg, rcsort_in_if, rcsort_out_if and the sorter RTL.
module record_insertion_sorter_tb;
	import rcsort_pkg::*;

	localparam int MAX_RECORDS  = MAX_RECORDS_DEF;
	localparam int RECORD_BYTES = RECORD_BYTES_DEF;
	localparam int ITEM_TARGET  = 850;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 400;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [REC_W-1:0] KEEP_MASK = {REC_W{1'b1}} >> (REC_W - 8 * RECORD_BYTES);

	typedef struct {
		logic [OP_W-1:0]  operation;
		logic [REC_W-1:0] rec_bits;
	} sort_request_t;

	typedef struct {
		logic [REC_W-1:0] record_out;
		logic             last_record;
		logic [ST_W-1:0]  status;
	} sort_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rcsort_in_if  req_ch();
	rcsort_out_if rsp_ch();

	record_insertion_sorter #(
		.MAX_RECORDS(MAX_RECORDS),
		.RECORD_BYTES(RECORD_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #4 clk = ~clk;

	sort_request_t    pending_requests[$];
	sort_reply_t      expected_replies[$];
	logic [REC_W-1:0] sorted_mirror[MAX_RECORDS];
	int unsigned      mirror_count = 0;
	int unsigned      mirror_read_ptr = 0;

	logic req_took = 1'b0;
	int   items_sent = 0;
	int   traffic_phase = 0;
	int   hold_left = 0;
	logic hold_done = 1'b0;
	int   cycle_count = 0;
	int   error_count = 0;
	int   replies_checked = 0;
	int   n_inserts = 0;
	int   n_full_drops = 0;
	int   n_reads = 0;
	int   n_empty_reads = 0;
	int   n_clears = 0;

	function automatic logic signed [7:0] key_of(input logic [REC_W-1:0] r);
		return r[7:0];
	endfunction

	function automatic logic [REC_W-1:0] random_record();
		logic [REC_W-1:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(5))
			0: r[7:0] = 8'h80;
			1: r[7:0] = 8'h7f;
			2: r[7:0] = 8'hff;
			3: r[7:0] = 8'($urandom_range(4));
			default: ;
		endcase
		return r;
	endfunction

	function automatic void push_request(input logic [OP_W-1:0] op, input logic [REC_W-1:0] r);
		sort_request_t item;
		item.operation = op;
		item.rec_bits  = r;
		pending_requests.push_back(item);
	endfunction

	// Applies one accepted item to the table mirror and queues the reply it must produce.
	function automatic void predict_sorted_reply(input logic [OP_W-1:0] op,
		input logic [REC_W-1:0] r);
		sort_reply_t      reply;
		logic [REC_W-1:0] kept;
		int unsigned      pos;
		reply.record_out  = '0;
		reply.last_record = 1'b0;
		reply.status      = ST_OK;
		case (op)
			OP_INSERT: begin
				mirror_read_ptr = 0;
				if (mirror_count >= MAX_RECORDS) begin
					reply.status = ST_FULL;
					n_full_drops++;
				end else begin
					kept = r & KEEP_MASK;
					pos = 0;
					while (pos < mirror_count && key_of(sorted_mirror[pos]) <= key_of(kept))
						pos++;
					for (int unsigned k = mirror_count; k > pos; k--)
						sorted_mirror[k] = sorted_mirror[k - 1];
					sorted_mirror[pos] = kept;
					mirror_count++;
					n_inserts++;
				end
			end
			OP_READ: begin
				if (mirror_read_ptr < mirror_count) begin
					reply.record_out  = sorted_mirror[mirror_read_ptr];
					reply.last_record = (mirror_read_ptr + 1 == mirror_count);
					mirror_read_ptr++;
					n_reads++;
				end else begin
					reply.status = ST_EMPTY;
					n_empty_reads++;
				end
			end
			OP_CLEAR: begin
				mirror_count    = 0;
				mirror_read_ptr = 0;
				n_clears++;
			end
			default: ;
		endcase
		expected_replies.push_back(reply);
	endfunction

	// Request driver: payload changes only at the falling edge.
	always @(negedge clk) begin : request_driver
		sort_request_t nxt;
		int            idle_pct;
		idle_pct = (traffic_phase == 1) ? 79 : (traffic_phase == 3) ? 26 : 0;
		if (arst_n && (req_took || !req_ch.valid)) begin
			if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
				nxt = pending_requests.pop_front();
				req_ch.valid     <= 1'b1;
				req_ch.operation <= nxt.operation;
				req_ch.record_in <= nxt.rec_bits;
				items_sent       <= items_sent + 1;
				traffic_phase    <= ((items_sent + 1) / 100) % 4;
			end else begin
				req_ch.valid     <= 1'b0;
				req_ch.operation <= OP_W'($urandom);
				req_ch.record_in <= {$urandom, $urandom};
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && replies_checked >= 250) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(negedge clk) begin : reply_acceptor
		int stall_pct;
		stall_pct = (traffic_phase == 2) ? 79 : (traffic_phase == 3) ? 26 : 0;
		if (arst_n)
			rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin : reply_monitor
		sort_reply_t want;
		if (!arst_n) begin
			req_took <= 1'b0;
		end else begin
			req_took <= req_ch.valid && req_ch.ready;
			if (req_ch.valid && req_ch.ready)
				predict_sorted_reply(req_ch.operation, req_ch.record_in);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: reply with nothing expected, record_out %h status %0d",
						$time, rsp_ch.record_out, rsp_ch.status);
					error_count++;
				end else begin
					want = expected_replies.pop_front();
					replies_checked++;
					if (rsp_ch.record_out !== want.record_out) begin
						$display("%0t: record_out mismatch, expected %h, got %h",
							$time, want.record_out, rsp_ch.record_out);
						error_count++;
					end
					if (rsp_ch.last_record !== want.last_record) begin
						$display("%0t: last_record mismatch, expected %b, got %b",
							$time, want.last_record, rsp_ch.last_record);
						error_count++;
					end
					if (rsp_ch.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, rsp_ch.status);
						error_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d items pending and %0d replies outstanding",
				$time, pending_requests.size(), expected_replies.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned planned_count;
		int unsigned n;
		logic        filled;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_INSERT;
		req_ch.record_in = '0;
		rsp_ch.ready     = 1'b0;
		planned_count    = 0;
		filled           = 1'b0;

		// Directed: empty-table read, unused code, key extremes, equal keys in
		// arrival order, a read-pointer restart by insert, and clear.
		push_request(OP_READ, '0);
		push_request(OP_UNUSED, {REC_W{1'b1}});
		push_request(OP_INSERT, {REC_W{1'b1}} ^ 64'h80);
		push_request(OP_INSERT, 64'h0000_0000_0000_0080);
		push_request(OP_INSERT, '0);
		push_request(OP_INSERT, 64'h1234_5678_9abc_deff);
		push_request(OP_INSERT, 64'ha5a5_a5a5_a5a5_a500);
		push_request(OP_INSERT, 64'h5a5a_5a5a_5a5a_5a01);
		push_request(OP_READ, '0);
		push_request(OP_READ, '0);
		push_request(OP_UNUSED, '0);
		push_request(OP_READ, '0);
		push_request(OP_INSERT, 64'hffff_0000_ffff_0000);
		for (int i = 0; i < 8; i++)
			push_request(OP_READ, {$urandom, $urandom});
		push_request(OP_CLEAR, {REC_W{1'b1}});
		push_request(OP_READ, '0);
		push_request(OP_INSERT, 64'h0f0f_0f0f_0f0f_0f7f);
		push_request(OP_READ, '0);
		push_request(OP_CLEAR, '0);

		while (pending_requests.size() < ITEM_TARGET) begin
			if (!filled && pending_requests.size() >= 250) begin
				// Fill the table past capacity, then read it out and one past the end.
				push_request(OP_CLEAR, random_record());
				for (int i = 0; i < MAX_RECORDS + 2; i++)
					push_request(OP_INSERT, random_record());
				for (int i = 0; i < MAX_RECORDS + 1; i++)
					push_request(OP_READ, random_record());
				push_request(OP_CLEAR, random_record());
				planned_count = 0;
				filled = 1'b1;
			end else begin
				if ($urandom_range(2) != 0) begin
					push_request(OP_CLEAR, random_record());
					planned_count = 0;
				end
				n = $urandom_range(1, 12);
				for (int unsigned i = 0; i < n; i++) begin
					push_request(OP_INSERT, random_record());
					if (planned_count < MAX_RECORDS)
						planned_count++;
					if ($urandom_range(5) == 0)
						push_request(OP_READ, random_record());
				end
				n = planned_count + $urandom_range(2);
				for (int unsigned i = 0; i < n; i++) begin
					push_request(OP_READ, random_record());
					if ($urandom_range(40) == 0)
						push_request(OP_UNUSED, random_record());
					if ($urandom_range(60) == 0) begin
						push_request(OP_CLEAR, random_record());
						planned_count = 0;
					end
				end
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (MAX_RECORDS + 8) @(posedge clk);

		$display("Sent %0d items: %0d inserts stored, %0d dropped on a full table, %0d clears.",
			items_sent, n_inserts, n_full_drops, n_clears);
		$display("Checked %0d replies: %0d records read back, %0d reads past the end.",
			replies_checked, n_reads, n_empty_reads);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
